[rtl/bdlp_pkg.sv]
// Package for the button debouncer with long-press detection.
// Holds the phase and event codes, register indexes and the shared structs.
// No dependencies.
package bdlp_pkg;

  localparam int unsigned LOCKOUT_W = 10;
  localparam int unsigned HOLD_W    = 12;
  localparam int unsigned STEP_W    = 8;
  localparam int unsigned GAP_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 12;

  // Register reset values
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_TIME_RST  = 10'd100;
  localparam logic [HOLD_W-1:0]    HOLD_TIME_RST     = 12'd800;
  localparam logic [STEP_W-1:0]    STEP_AMOUNT_RST   = 8'd10;
  localparam logic [STEP_W-1:0]    STEP_INTERVAL_RST = 8'd10;

  localparam logic [GAP_W-1:0]  GAP_MAX      = 8'd255;
  localparam logic [STEP_W-1:0] INTERVAL_MAX = 8'd254;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TIME  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_AMOUNT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd3;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_LONG     = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE     = 2'd0,
    EV_PRESSED  = 2'd1,
    EV_RELEASED = 2'd2,
    EV_LONG     = 2'd3
  } event_t;

  typedef struct packed {
    logic [LOCKOUT_W-1:0] lockout_time;
    logic [HOLD_W-1:0]    hold_time;
    logic [STEP_W-1:0]    step_amount;
    logic [STEP_W-1:0]    step_interval;
  } bdlp_cfg_t;

  typedef struct packed {
    event_t event_code;
    logic   switch_now;
  } bdlp_res_t;

endpackage

[rtl/bdlp_core.sv]
// State update of the debouncer: accepted level, press phase, lockout and
// hold counters with their elapsed-tick counters. Uses bdlp_pkg.
module bdlp_core
  import bdlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_vld,
  input  logic      switch_low,
  input  bdlp_cfg_t cfg,
  output bdlp_res_t res
);

  logic                 level_r, level_nxt;
  phase_t               phase_r, phase_nxt;
  logic [LOCKOUT_W-1:0] lockout_r, lockout_nxt;
  logic [HOLD_W-1:0]    hold_r, hold_nxt;
  logic [GAP_W-1:0]     lgap_r, lgap_nxt;
  logic [GAP_W-1:0]     hgap_r, hgap_nxt;

  logic                 sw;
  logic [STEP_W-1:0]    step;
  logic [STEP_W-1:0]    interval;
  logic [GAP_W-1:0]     lgap_inc;
  logic [GAP_W-1:0]     hgap_inc;
  logic [LOCKOUT_W-1:0] lockout_dec;
  logic [HOLD_W-1:0]    hold_dec;
  event_t               ev;

  assign sw       = ~switch_low;
  assign step     = (cfg.step_amount == '0) ? STEP_W'(1) : cfg.step_amount;
  assign interval = (cfg.step_interval > INTERVAL_MAX) ? INTERVAL_MAX : cfg.step_interval;
  assign lgap_inc = (lgap_r == GAP_MAX) ? GAP_MAX : lgap_r + GAP_W'(1);
  assign hgap_inc = (hgap_r == GAP_MAX) ? GAP_MAX : hgap_r + GAP_W'(1);

  // Saturating subtractions
  assign lockout_dec = (lockout_r > LOCKOUT_W'(step)) ? lockout_r - LOCKOUT_W'(step) : '0;
  assign hold_dec    = (hold_r > HOLD_W'(step)) ? hold_r - HOLD_W'(step) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= 1'b0;
      phase_r   <= PH_RELEASED;
      lockout_r <= '0;
      hold_r    <= HOLD_TIME_RST;
      lgap_r    <= '0;
      hgap_r    <= '0;
    end else begin
      level_r   <= level_nxt;
      phase_r   <= phase_nxt;
      lockout_r <= lockout_nxt;
      hold_r    <= hold_nxt;
      lgap_r    <= lgap_nxt;
      hgap_r    <= hgap_nxt;
    end
  end

  always_comb begin
    level_nxt   = level_r;
    phase_nxt   = phase_r;
    lockout_nxt = lockout_r;
    hold_nxt    = hold_r;
    lgap_nxt    = lgap_r;
    hgap_nxt    = hgap_r;
    ev          = EV_NONE;
    if (item_vld) begin
      lgap_nxt = lgap_inc;
      hgap_nxt = hgap_inc;
      if (sw != level_r) begin
        if (lockout_r == '0) begin
          lockout_nxt = cfg.lockout_time;
          level_nxt   = sw;
          if (sw) begin
            phase_nxt = PH_PRESSED;
            hold_nxt  = cfg.hold_time;
            ev        = EV_PRESSED;
          end else begin
            phase_nxt = PH_RELEASED;
            ev        = EV_RELEASED;
          end
        end else if (lgap_inc > interval) begin
          lockout_nxt = lockout_dec;
          lgap_nxt    = '0;
        end
      end else begin
        unique case (phase_r)
          PH_PRESSED: begin
            if (hold_r == '0) begin
              hold_nxt  = cfg.hold_time;
              phase_nxt = PH_LONG;
              ev        = EV_LONG;
            end else if (hgap_inc > interval) begin
              hold_nxt = hold_dec;
              hgap_nxt = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign res.event_code = ev;
  assign res.switch_now = sw;

endmodule

[rtl/button_debounce_long_press.sv]
// Push-button debouncer with long-press detection, one input beat per
// millisecond tick. Each accepted input beat yields exactly one result beat,
// in order. The whole state update is a few compares and saturating
// subtractions between the state registers and a two-entry result buffer,
// so a beat can be accepted in every cycle while in_tready is high. in_tready
// falls only once both result entries are held by a stalled output.
// Configuration writes are always taken (cfg_ready is high) and should be
// made while no result is pending. Uses bdlp_pkg and bdlp_core.
module button_debounce_long_press
  import bdlp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input beat
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] switch_low, [7:1] zero
  // result beat
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [1:0] event_code, [2] switch_now, [7:3] zero
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  bdlp_cfg_t cfg_r;
  bdlp_res_t res;
  bdlp_res_t main_r, skid_r;
  logic      main_vld_r, skid_vld_r;
  logic      in_acc;
  logic      main_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_time  <= LOCKOUT_TIME_RST;
      cfg_r.hold_time     <= HOLD_TIME_RST;
      cfg_r.step_amount   <= STEP_AMOUNT_RST;
      cfg_r.step_interval <= STEP_INTERVAL_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOCKOUT_TIME:  cfg_r.lockout_time  <= cfg_data[LOCKOUT_W-1:0];
        REG_HOLD_TIME:     cfg_r.hold_time     <= cfg_data[HOLD_W-1:0];
        REG_STEP_AMOUNT:   cfg_r.step_amount   <= cfg_data[STEP_W-1:0];
        REG_STEP_INTERVAL: cfg_r.step_interval <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_tready = ~skid_vld_r;
  assign in_acc    = in_tvalid & in_tready;

  bdlp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (in_acc),
    .switch_low(in_tdata[0]),
    .cfg       (cfg_r),
    .res       (res)
  );

  // Two-entry result buffer: the skid entry catches a beat while the
  // main entry is stalled and drains into it first.
  assign main_free = ~main_vld_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (main_free) begin
      if (skid_vld_r) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_vld_r) begin
        main_r <= skid_r;
      end else if (in_acc) begin
        main_r <= res;
      end
    end else if (in_acc) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = main_vld_r;
  assign out_tdata  = {5'd0, main_r.switch_now, main_r.event_code};

endmodule
